// ===== sv/tepq_pkg.sv =====
// shared constants and types for the timed event priority queue
`timescale 1ns / 1ps
`default_nettype none

package tepq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int ID_BITS_DEF   = 16;
    localparam int TIME_BITS_DEF = 64;
    localparam int CMD_BITS      = 2;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_PEEK   = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    // per-cycle operation broadcast to every cell
    typedef struct packed {
        logic add_en;
        logic rem_en;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== sv/tepq_cell.sv =====
// one slot of the sorted queue, shifts toward the tail on insert and toward the head on delete
`timescale 1ns / 1ps
`default_nettype none

module tepq_cell #(
    parameter int ID_BITS   = 16,
    parameter int TIME_BITS = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire tepq_pkg::cell_ctl_t   ctl,
    input  wire logic [ID_BITS-1:0]    key_id,
    input  wire logic [TIME_BITS-1:0]  key_time,
    input  wire logic                  prev_valid,
    input  wire logic [ID_BITS-1:0]    prev_id,
    input  wire logic [TIME_BITS-1:0]  prev_time,
    input  wire logic                  prev_shift,
    input  wire logic                  next_valid,
    input  wire logic [ID_BITS-1:0]    next_id,
    input  wire logic [TIME_BITS-1:0]  next_time,
    input  wire logic                  later_in,
    input  wire logic                  hit_in,
    output logic                       shift_out,
    output logic                       later_out,
    output logic                       hit_out,
    output logic                       slot_valid,
    output logic [ID_BITS-1:0]         slot_id,
    output logic [TIME_BITS-1:0]       slot_time
);
    import tepq_pkg::*;

    logic                 valid_reg, valid_next;
    logic [ID_BITS-1:0]   id_reg, id_next;
    logic [TIME_BITS-1:0] time_reg, time_next;
    logic                 match;
    logic                 target;

    // insert point: first empty slot or first slot due strictly later
    assign shift_out = !valid_reg || (time_reg > key_time);
    assign match     = valid_reg && (id_reg == key_id);
    // delete the match nearest the tail
    assign later_out = later_in | match;
    assign target    = match & !later_in;
    assign hit_out   = hit_in | target;

    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        time_next  = time_reg;
        if (ctl.add_en)
        begin
            if (prev_shift)
            begin
                valid_next = prev_valid;
                id_next    = prev_id;
                time_next  = prev_time;
            end
            else if (shift_out)
            begin
                valid_next = 1'b1;
                id_next    = key_id;
                time_next  = key_time;
            end
        end
        else if (ctl.rem_en && hit_out)
        begin
            valid_next = next_valid;
            id_next    = next_id;
            time_next  = next_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        time_reg <= time_next;
    end

    assign slot_valid = valid_reg;
    assign slot_id    = id_reg;
    assign slot_time  = time_reg;

endmodule

`default_nettype wire

// ===== sv/timed_event_priority_queue.sv =====
// timed event priority queue: a sorted chain of slot cells with a registered response
// order: the cells update on the command transfer, then the head is captured into the
// response register once that register is free
// throughput: one command per cycle while cmd_ready is high; the whole chain of cells updates together
// reset: all slots empty, count zero, no response pending; slot payload is not reset
// stalls: a held response stalls the command side only when a second result is also waiting
`timescale 1ns / 1ps
`default_nettype none

module timed_event_priority_queue #(
    parameter int DEPTH     = tepq_pkg::DEPTH_DEF,
    parameter int ID_BITS   = tepq_pkg::ID_BITS_DEF,
    parameter int TIME_BITS = tepq_pkg::TIME_BITS_DEF,
    parameter int CW        = $clog2(DEPTH + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // command channel
    input  wire logic                          cmd_valid,
    output logic                               cmd_ready,
    input  wire logic [tepq_pkg::CMD_BITS-1:0] command,
    input  wire logic [ID_BITS-1:0]            event_id,
    input  wire logic [TIME_BITS-1:0]          event_time,
    // response channel
    output logic                               rsp_valid,
    input  wire logic                          rsp_ready,
    output logic                               success,
    output logic                               head_valid,
    output logic [ID_BITS-1:0]                 head_id,
    output logic [TIME_BITS-1:0]               head_time,
    output logic [CW-1:0]                      entry_count
);
    import tepq_pkg::*;

    // chain wiring; the later and hit chains carry one extra position for their boundary value
    logic [DEPTH-1:0]   slot_valid;
    logic [ID_BITS-1:0] slot_id   [DEPTH];
    logic [TIME_BITS-1:0] slot_time [DEPTH];
    logic [DEPTH-1:0]   shift_vec;
    logic [DEPTH:0]     later_vec;   // later_vec[i]: a match at index i or above
    logic [DEPTH:0]     hit_vec;     // hit_vec[i]: the delete target lies below index i

    cell_ctl_t          ctl;
    logic               cmd_xfer;
    logic               rsp_free;
    logic               queue_full;
    logic               add_ok;
    logic               rem_ok;
    logic               op_ok;

    // pending result: cells already updated, head captured once the response register is free
    logic               pend_reg, pend_next;
    logic               ok_reg, ok_next;
    logic [CW-1:0]      count_reg, count_next;

    // response register
    logic               rsp_valid_reg, rsp_valid_next;
    logic               success_reg, success_next;
    logic               head_valid_reg, head_valid_next;
    logic [ID_BITS-1:0] head_id_reg, head_id_next;
    logic [TIME_BITS-1:0] head_time_reg, head_time_next;
    logic [CW-1:0]      entry_count_reg, entry_count_next;

    assign rsp_free   = !rsp_valid_reg || rsp_ready;
    assign cmd_ready  = !pend_reg || rsp_free;
    assign cmd_xfer   = cmd_valid && cmd_ready;
    assign queue_full = slot_valid[DEPTH-1];

    // a remove with no match leaves every cell in place on its own
    assign add_ok     = cmd_xfer && (command == CMD_ADD) && !queue_full;
    assign rem_ok     = cmd_xfer && (command == CMD_REMOVE) && later_vec[0];

    assign ctl = '{add_en: add_ok, rem_en: cmd_xfer && (command == CMD_REMOVE)};

    always_comb
    begin
        case (cmd_t'(command))
            CMD_ADD:    op_ok = !queue_full;
            CMD_REMOVE: op_ok = later_vec[0];
            CMD_PEEK:   op_ok = (count_reg != '0);
            default:    op_ok = 1'b0;
        endcase
    end

    // boundary values of the neighbor chains
    assign later_vec[DEPTH] = 1'b0;
    assign hit_vec[0]       = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic                 p_valid;
            logic [ID_BITS-1:0]   p_id;
            logic [TIME_BITS-1:0] p_time;
            logic                 p_shift;
            logic                 n_valid;
            logic [ID_BITS-1:0]   n_id;
            logic [TIME_BITS-1:0] n_time;

            if (gi == 0)
            begin : g_head
                assign p_valid = 1'b0;
                assign p_id    = '0;
                assign p_time  = '0;
                assign p_shift = 1'b0;
            end
            else
            begin : g_body
                assign p_valid = slot_valid[gi-1];
                assign p_id    = slot_id[gi-1];
                assign p_time  = slot_time[gi-1];
                assign p_shift = shift_vec[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign n_valid = 1'b0;
                assign n_id    = '0;
                assign n_time  = '0;
            end
            else
            begin : g_inner
                assign n_valid = slot_valid[gi+1];
                assign n_id    = slot_id[gi+1];
                assign n_time  = slot_time[gi+1];
            end

            tepq_cell #(
                .ID_BITS   (ID_BITS),
                .TIME_BITS (TIME_BITS)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .key_id     (event_id),
                .key_time   (event_time),
                .prev_valid (p_valid),
                .prev_id    (p_id),
                .prev_time  (p_time),
                .prev_shift (p_shift),
                .next_valid (n_valid),
                .next_id    (n_id),
                .next_time  (n_time),
                .later_in   (later_vec[gi+1]),
                .hit_in     (hit_vec[gi]),
                .shift_out  (shift_vec[gi]),
                .later_out  (later_vec[gi]),
                .hit_out    (hit_vec[gi+1]),
                .slot_valid (slot_valid[gi]),
                .slot_id    (slot_id[gi]),
                .slot_time  (slot_time[gi])
            );
        end
    endgenerate

    always_comb
    begin
        pend_next        = pend_reg;
        ok_next          = ok_reg;
        count_next       = count_reg;
        rsp_valid_next   = rsp_valid_reg;
        success_next     = success_reg;
        head_valid_next  = head_valid_reg;
        head_id_next     = head_id_reg;
        head_time_next   = head_time_reg;
        entry_count_next = entry_count_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        // move the finished result into the response register
        if (pend_reg && rsp_free)
        begin
            pend_next        = 1'b0;
            rsp_valid_next   = 1'b1;
            success_next     = ok_reg;
            head_valid_next  = slot_valid[0];
            head_id_next     = slot_valid[0] ? slot_id[0] : '0;
            head_time_next   = slot_valid[0] ? slot_time[0] : '0;
            entry_count_next = count_reg;
        end

        if (cmd_xfer)
        begin
            pend_next = 1'b1;
            ok_next   = op_ok;
            if (add_ok)
            begin
                count_next = count_reg + CW'(1);
            end
            else if (rem_ok)
            begin
                count_next = count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg          <= ok_next;
        success_reg     <= success_next;
        head_valid_reg  <= head_valid_next;
        head_id_reg     <= head_id_next;
        head_time_reg   <= head_time_next;
        entry_count_reg <= entry_count_next;
    end

    assign rsp_valid   = rsp_valid_reg;
    assign success     = success_reg;
    assign head_valid  = head_valid_reg;
    assign head_id     = head_id_reg;
    assign head_time   = head_time_reg;
    assign entry_count = entry_count_reg;

    // occupied slots always form a run starting at the head
    a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        ((slot_valid & (slot_valid + DEPTH'(1))) == '0))
        else $error("gap in occupied slots");

    // the count tracks the occupied cells
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(slot_valid) == int'(count_reg)))
        else $error("entry count disagrees with occupied cells");

    // an add on a full queue leaves the count alone
    a_full_add: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_xfer && (command == CMD_ADD) && queue_full) |=> (count_reg == $past(count_reg)))
        else $error("add on full queue changed the count");

    // a remove that finds its id shrinks the queue by one
    a_remove: assert property (@(posedge clk) disable iff (!rst_n)
        rem_ok |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("successful remove did not shrink the queue");

endmodule

`default_nettype wire
